>>> design/cartridge_bank_mapper_irq_defines.svh
// Assertion macros for the cartridge bank mapper.
`ifndef CARTRIDGE_BANK_MAPPER_IRQ_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_IRQ_DEFINES_SVH

`ifndef SYNTHESIS
`define CBM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cartridge mapper check failed");
`define CBM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cartridge mapper check failed");
`else
`define CBM_ASSERT_NOW(label, clk, rst, ante, cons)
`define CBM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> design/cbm_pkg.sv
// Shared types and constants of the cartridge bank mapper.
package cbm_pkg;

   localparam int unsigned RAM_PAGES_DEF = 4;
   localparam int unsigned PATTERN_SLOTS = 8;
   localparam int unsigned CMD_W = 2;
   localparam int unsigned ADDR_W = 16;
   localparam int unsigned DATA_W = 8;
   localparam int unsigned PHYS_W = 21;
   localparam int unsigned TGT_W = 2;
   localparam int unsigned MIRROR_W = 2;
   localparam int unsigned BANK_W = 8;
   localparam int unsigned COUNT_W = 9;
   localparam int unsigned DIV_STEPS = BANK_W;
   localparam int unsigned STEP_W = $clog2(DIV_STEPS);

   localparam logic [COUNT_W-1:0] MAX_BANKS = 9'd256;
   localparam logic [COUNT_W-1:0] PRG_COUNT_RST = 9'd32;
   localparam logic [COUNT_W-1:0] CHR_COUNT_RST = 9'd256;

   localparam logic [CMD_W-1:0] KIND_CPU_READ = 2'd0;
   localparam logic [CMD_W-1:0] KIND_CPU_WRITE = 2'd1;
   localparam logic [CMD_W-1:0] KIND_PATTERN = 2'd2;
   localparam logic [CMD_W-1:0] KIND_TICK = 2'd3;

   localparam logic [TGT_W-1:0] TGT_NONE = 2'd0;
   localparam logic [TGT_W-1:0] TGT_PRG = 2'd1;
   localparam logic [TGT_W-1:0] TGT_RAM = 2'd2;
   localparam logic [TGT_W-1:0] TGT_CHR = 2'd3;

   localparam logic CSR_PRG_COUNT = 1'b0;
   localparam logic CSR_CHR_COUNT = 1'b1;

   localparam logic [3:0] REG_WINDOW = 4'h8;
   localparam logic [3:0] REG_PRG0 = 4'h9;
   localparam logic [3:0] REG_PRG1 = 4'hA;
   localparam logic [3:0] REG_PRG2 = 4'hB;
   localparam logic [3:0] REG_MIRROR = 4'hC;
   localparam logic [3:0] REG_IRQ_CTRL = 4'hD;
   localparam logic [3:0] REG_COUNT_LO = 4'hE;
   localparam logic [3:0] REG_COUNT_HI = 4'hF;

   typedef struct packed {
      logic start;
      logic step;
      logic load;
   } cbm_cmd_type;

endpackage

>>> design/cbm_channels.sv
// Valid/ready channel interfaces for mapper requests and responses.
interface cbm_req_if;
   logic                        valid;
   logic                        ready;
   logic [cbm_pkg::CMD_W-1:0]   cmd;
   logic [cbm_pkg::ADDR_W-1:0]  address;
   logic [cbm_pkg::DATA_W-1:0]  data;

   modport source (output valid, output cmd, output address, output data, input ready);
   modport sink (input valid, input cmd, input address, input data, output ready);
endinterface

interface cbm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cbm_pkg::TGT_W-1:0]     target;
   logic [cbm_pkg::PHYS_W-1:0]    phys_address;
   logic                          ram_write;
   logic [cbm_pkg::MIRROR_W-1:0]  mirroring;
   logic                          irq_line;

   modport source (output valid, output target, output phys_address, output ram_write,
                   output mirroring, output irq_line, input ready);
   modport sink (input valid, input target, input phys_address, input ram_write,
                 input mirroring, input irq_line, output ready);
endinterface

>>> design/cbm_ctrl.sv
// Sequencer of the mapper: accept, remainder steps, result handoff.
`include "cartridge_bank_mapper_irq_defines.svh"

module cbm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output cbm_pkg::cbm_cmd_type cmd
);
   import cbm_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_STEP = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               cnt_in = '0;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.load | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `CBM_ASSERT_NEXT(a_start_steps, clock, reset, cmd.start, state_ff == ST_STEP && cnt_ff == '0)
   `CBM_ASSERT_NEXT(a_last_done, clock, reset, state_ff == ST_STEP && cnt_ff == LAST_STEP, state_ff == ST_DONE)
   `CBM_ASSERT_NEXT(a_load_valid, clock, reset, cmd.load, rsp_valid_ff && state_ff == ST_IDLE)
endmodule

>>> design/cbm_dpath.sv
// Mapper datapath: bank registers, IRQ timer, remainder unit, result register.
`include "cartridge_bank_mapper_irq_defines.svh"

module cbm_dpath #(
   parameter int unsigned RAM_PAGES = cbm_pkg::RAM_PAGES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic                           csr_index,
   input  logic [cbm_pkg::COUNT_W-1:0]    csr_data,
   input  logic [cbm_pkg::CMD_W-1:0]      req_cmd,
   input  logic [cbm_pkg::ADDR_W-1:0]     req_address,
   input  logic [cbm_pkg::DATA_W-1:0]     req_data,
   input  cbm_pkg::cbm_cmd_type           cmd,
   output logic [cbm_pkg::TGT_W-1:0]      rsp_target,
   output logic [cbm_pkg::PHYS_W-1:0]     rsp_phys_address,
   output logic                           rsp_ram_write,
   output logic [cbm_pkg::MIRROR_W-1:0]   rsp_mirroring,
   output logic                           rsp_irq_line
);
   import cbm_pkg::*;

   localparam logic [COUNT_W-1:0] RAM_DIVISOR = COUNT_W'(RAM_PAGES);

   logic [COUNT_W-1:0]  prg_cnt_ff, chr_cnt_ff;
   logic [3:0]          cmd_sel_ff;
   logic [BANK_W-1:0]   pat_ff [PATTERN_SLOTS];
   logic [5:0]          prg_bank_ff [3];
   logic [7:0]          window_ff;
   logic [1:0]          mirror_ff;
   logic                ien_ff, ien_in;
   logic                cen_ff, cen_in;
   logic [15:0]         count_ff, count_in;
   logic                pend_ff, pend_in;

   logic [TGT_W-1:0]    tgt_ff, tgt_in;
   logic                wr_ff, wr_in;
   logic                big_ff, big_in;
   logic [12:0]         off_ff, off_in;
   logic [BANK_W-1:0]   dvd_ff, dvd_in;
   logic [COUNT_W-1:0]  dsr_ff, dsr_in;
   logic [COUNT_W-1:0]  rem_ff, rem_in, rem_shift;

   logic [TGT_W-1:0]    out_tgt_ff;
   logic [PHYS_W-1:0]   out_phys_ff, phys_in;
   logic                out_wr_ff;
   logic [1:0]          out_mirror_ff;
   logic                out_irq_ff;

   logic [COUNT_W-1:0]  prg_eff, chr_eff;
   logic [BANK_W-1:0]   prg_last;
   logic                sel_write, reg_write, tick;

   // Decode the incoming beat.
   always_comb begin
      prg_eff = (prg_cnt_ff > MAX_BANKS) ? MAX_BANKS : prg_cnt_ff;
      chr_eff = (chr_cnt_ff > MAX_BANKS) ? MAX_BANKS : chr_cnt_ff;
      prg_last = BANK_W'(prg_eff - 1'b1);
      tgt_in = TGT_NONE;
      wr_in = 1'b0;
      big_in = 1'b1;
      off_in = req_address[12:0];
      dvd_in = '0;
      dsr_in = prg_eff;
      sel_write = 1'b0;
      reg_write = 1'b0;
      tick = 1'b0;
      case (req_cmd)
         KIND_CPU_READ, KIND_CPU_WRITE: begin
            if (req_address[15:13] == 3'd3) begin
               if (window_ff[6]) begin
                  if (window_ff[7]) begin
                     tgt_in = TGT_RAM;
                     dvd_in = {2'b00, window_ff[5:0]};
                     dsr_in = RAM_DIVISOR;
                     wr_in = (req_cmd == KIND_CPU_WRITE);
                  end
               end else if (req_cmd == KIND_CPU_READ && prg_eff != '0) begin
                  tgt_in = TGT_PRG;
                  dvd_in = {2'b00, window_ff[5:0]};
               end
            end else if (req_address[15]) begin
               if (req_cmd == KIND_CPU_READ) begin
                  if (prg_eff != '0) begin
                     tgt_in = TGT_PRG;
                     case (req_address[14:13])
                        2'd0: dvd_in = {2'b00, prg_bank_ff[0]};
                        2'd1: dvd_in = {2'b00, prg_bank_ff[1]};
                        2'd2: dvd_in = {2'b00, prg_bank_ff[2]};
                        default: dvd_in = prg_last;
                     endcase
                  end
               end else if (req_address[14:13] == 2'd0) begin
                  sel_write = 1'b1;
               end else if (req_address[14:13] == 2'd1) begin
                  reg_write = 1'b1;
               end
            end
         end
         KIND_PATTERN: begin
            big_in = 1'b0;
            off_in = {3'b000, req_address[9:0]};
            dvd_in = pat_ff[req_address[12:10]];
            dsr_in = chr_eff;
            if (chr_eff != '0) begin
               tgt_in = TGT_CHR;
            end
         end
         default: begin
            tick = 1'b1;
         end
      endcase
   end

   // Timer and IRQ control.
   always_comb begin
      ien_in = ien_ff;
      cen_in = cen_ff;
      count_in = count_ff;
      pend_in = pend_ff;
      if (cmd.start && reg_write) begin
         case (cmd_sel_ff)
            REG_IRQ_CTRL: begin
               ien_in = req_data[0];
               cen_in = req_data[7];
               pend_in = 1'b0;
            end
            REG_COUNT_LO: count_in = {count_ff[15:8], req_data};
            REG_COUNT_HI: count_in = {req_data, count_ff[7:0]};
            default: count_in = count_ff;
         endcase
      end
      if (cmd.start && tick && cen_ff) begin
         count_in = count_ff - 1'b1;
         if (count_ff == '0 && ien_ff) begin
            pend_in = 1'b1;
         end
      end
   end

   // One remainder bit per step.
   always_comb begin
      rem_shift = {rem_ff[BANK_W-1:0], dvd_ff[BANK_W-1]};
      rem_in = (rem_shift >= dsr_ff) ? rem_shift - dsr_ff : rem_shift;
      phys_in = '0;
      if (tgt_ff != TGT_NONE) begin
         phys_in = big_ff ? {rem_ff[BANK_W-1:0], off_ff}
                          : {3'b000, rem_ff[BANK_W-1:0], off_ff[9:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_cnt_ff <= PRG_COUNT_RST;
         chr_cnt_ff <= CHR_COUNT_RST;
         cmd_sel_ff <= '0;
         for (int i = 0; i < PATTERN_SLOTS; i++) begin
            pat_ff[i] <= '0;
         end
         for (int i = 0; i < 3; i++) begin
            prg_bank_ff[i] <= '0;
         end
         window_ff <= '0;
         mirror_ff <= '0;
         ien_ff <= 1'b0;
         cen_ff <= 1'b0;
         count_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_PRG_COUNT) begin
               prg_cnt_ff <= csr_data;
            end else begin
               chr_cnt_ff <= csr_data;
            end
         end
         if (cmd.start && sel_write) begin
            cmd_sel_ff <= req_data[3:0];
         end
         if (cmd.start && reg_write) begin
            if (!cmd_sel_ff[3]) begin
               pat_ff[cmd_sel_ff[2:0]] <= req_data;
            end
            case (cmd_sel_ff)
               REG_WINDOW: window_ff <= req_data;
               REG_PRG0: prg_bank_ff[0] <= req_data[5:0];
               REG_PRG1: prg_bank_ff[1] <= req_data[5:0];
               REG_PRG2: prg_bank_ff[2] <= req_data[5:0];
               REG_MIRROR: mirror_ff <= req_data[1:0];
               default: mirror_ff <= mirror_ff;
            endcase
         end
         ien_ff <= ien_in;
         cen_ff <= cen_in;
         count_ff <= count_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         tgt_ff <= tgt_in;
         wr_ff <= wr_in;
         big_ff <= big_in;
         off_ff <= off_in;
         dvd_ff <= dvd_in;
         dsr_ff <= dsr_in;
         rem_ff <= '0;
      end else if (cmd.step) begin
         rem_ff <= rem_in;
         dvd_ff <= {dvd_ff[BANK_W-2:0], 1'b0};
      end
      if (cmd.load) begin
         out_tgt_ff <= tgt_ff;
         out_phys_ff <= phys_in;
         out_wr_ff <= wr_ff;
         out_mirror_ff <= mirror_ff;
         out_irq_ff <= pend_ff;
      end
   end

   assign rsp_target = out_tgt_ff;
   assign rsp_phys_address = out_phys_ff;
   assign rsp_ram_write = out_wr_ff;
   assign rsp_mirroring = out_mirror_ff;
   assign rsp_irq_line = out_irq_ff;

   `CBM_ASSERT_NEXT(a_irq_wrap, clock, reset, cmd.start && tick && cen_ff && ien_ff && count_ff == '0, pend_ff)
   `CBM_ASSERT_NOW(a_rem_range, clock, reset, cmd.load && tgt_ff != TGT_NONE, rem_ff < dsr_ff)
endmodule

>>> design/cartridge_bank_mapper_irq.sv
// Cartridge bank mapper with CPU-cycle IRQ timer: top level.
// After a request beat is accepted, the sequencer runs the 8-step bank remainder unit, then
// loads the output register in its done state once that register is free; no new request is taken
// until it is back in idle. A finished response waits in the output register while the next request is taken.
// Reset (synchronous, active high) clears all bank, window, mirroring and timer state
// and sets the bank counts to 32 program and 256 pattern banks.
module cartridge_bank_mapper_irq #(
   parameter int unsigned RAM_PAGES = cbm_pkg::RAM_PAGES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write,
   input  logic                         csr_index,
   input  logic [cbm_pkg::COUNT_W-1:0]  csr_data,
   cbm_req_if.sink                      req_chan,
   cbm_rsp_if.source                    rsp_chan
);
   import cbm_pkg::*;

   cbm_cmd_type cmd;

   cbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   cbm_dpath #(
      .RAM_PAGES (RAM_PAGES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_cmd          (req_chan.cmd),
      .req_address      (req_chan.address),
      .req_data         (req_chan.data),
      .cmd              (cmd),
      .rsp_target       (rsp_chan.target),
      .rsp_phys_address (rsp_chan.phys_address),
      .rsp_ram_write    (rsp_chan.ram_write),
      .rsp_mirroring    (rsp_chan.mirroring),
      .rsp_irq_line     (rsp_chan.irq_line)
   );
endmodule
